// ===== rtl/core/ed_pkg.sv =====
// Shared types, constants and byte fold function for the edit distance engine
`timescale 1ns / 1ps
package ed_pkg;

  localparam int DEF_MAX_QUERY = 64;
  localparam logic [15:0] TARGET_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_TARGET = 2'd2,
    KIND_FINISH = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } item_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    if (en && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/edit_distance.sv =====
// Top level of the Levenshtein edit distance engine
// Query, clear and saturated target items are handled in the idle state.
// A target item steps through S_READ and S_CALC once for each DP cell of the
// query, as the DP row memory has a registered read.
// Finish goes S_FREAD, S_FDATA, S_EMIT; with no query, straight to S_EMIT.
// Synchronous active-low reset: empty query and target, fold_case set.
`timescale 1ns / 1ps
module edit_distance
  import ed_pkg::*;
#(
  parameter int MAX_QUERY = DEF_MAX_QUERY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_distance,
  output logic        out_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_fold_case
);

  logic  fold_r;
  logic  q_valid, q_pop;
  item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r <= 1'b1;
    end else if (cfg_valid) begin
      fold_r <= cfg_fold_case;
    end
  end

  ed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .in_ch    (in_ch),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  ed_back #(.MAX_QUERY(MAX_QUERY)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .fold_case    (fold_r),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_distance (out_distance),
    .out_overflow (out_overflow)
  );

endmodule

// ===== rtl/core/ed_front.sv =====
// Input stage: accepts items and queues them for the back end
`timescale 1ns / 1ps
module ed_front
  import ed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_ch,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t      fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_valid && q_pop;
  assign q_item   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{kind: kind_t'(in_kind), ch: in_ch};
    end
  end

endmodule

// ===== rtl/core/ed_back.sv =====
// Back end: query store, DP row memory and cell update sequencer
`timescale 1ns / 1ps
module ed_back
  import ed_pkg::*;
#(
  parameter int MAX_QUERY = DEF_MAX_QUERY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fold_case,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_distance,
  output logic        out_overflow
);

  localparam int DA_W = $clog2(MAX_QUERY + 1);
  localparam int QA_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CALC, S_FREAD, S_FDATA, S_EMIT
  } state_t;

  state_t            state_r;
  logic [DA_W-1:0]   ql_r, idx_r;
  logic [15:0]       tl_r, diag_r, left_r, fin_r, dist_r;
  logic              ovf_r, out_valid_r, oovf_r;
  logic [7:0]        tc_r, qrd_r;
  logic [15:0]       drd_r;
  logic [7:0]        qmem [MAX_QUERY];
  logic [15:0]       dmem [MAX_QUERY + 1];

  logic              take, q_we, d_we, neq;
  logic [DA_W-1:0]   d_waddr, d_raddr, ql_inc, idx_dec;
  logic [QA_W-1:0]   q_raddr;
  logic [15:0]       d_wdata, cell_cost;
  logic [16:0]       ca, cb, cc, cm;

  assign q_pop        = (state_r == S_IDLE);
  assign take         = q_pop && q_valid;
  assign out_valid    = out_valid_r;
  assign out_distance = dist_r;
  assign out_overflow = oovf_r;
  assign ql_inc       = ql_r + DA_W'(1);
  assign idx_dec      = idx_r - DA_W'(1);
  assign q_raddr      = idx_dec[QA_W-1:0];
  assign d_raddr      = (state_r == S_FREAD) ? ql_r : idx_r;

  always_comb begin
    neq       = (fold_byte(qrd_r, fold_case) != tc_r);
    ca        = {1'b0, drd_r} + 17'd1;
    cb        = {1'b0, left_r} + 17'd1;
    cc        = {1'b0, diag_r} + {16'd0, neq};
    cm        = (ca < cb) ? ca : cb;
    cm        = (cm < cc) ? cm : cc;
    cell_cost = cm[16] ? 16'hFFFF : cm[15:0];
  end

  always_comb begin
    q_we    = take && q_item.kind == KIND_QUERY && tl_r == 16'd0
              && ql_r != DA_W'(MAX_QUERY);
    d_we    = q_we || state_r == S_CALC;
    d_waddr = (state_r == S_CALC) ? idx_r : ql_inc;
    d_wdata = (state_r == S_CALC) ? cell_cost : 16'(ql_inc);
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[ql_r[QA_W-1:0]] <= q_item.ch;
    end
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    qrd_r <= qmem[q_raddr];
    drd_r <= dmem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ql_r        <= '0;
      tl_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            unique case (q_item.kind)
              KIND_CLEAR: begin
                ql_r  <= '0;
                tl_r  <= '0;
                ovf_r <= 1'b0;
              end
              KIND_QUERY: begin
                if (tl_r == 16'd0) begin
                  if (ql_r == DA_W'(MAX_QUERY)) begin
                    ovf_r <= 1'b1;
                  end else begin
                    ql_r <= ql_inc;
                  end
                end
              end
              KIND_TARGET: begin
                if (tl_r == TARGET_MAX) begin
                  ovf_r <= 1'b1;
                end else begin
                  tc_r   <= fold_byte(q_item.ch, fold_case);
                  diag_r <= tl_r;
                  left_r <= tl_r + 16'd1;
                  tl_r   <= tl_r + 16'd1;
                  idx_r  <= DA_W'(1);
                  if (ql_r != '0) begin
                    state_r <= S_READ;
                  end
                end
              end
              KIND_FINISH: begin
                if (ql_r == '0) begin
                  fin_r   <= tl_r;
                  state_r <= S_EMIT;
                end else begin
                  state_r <= S_FREAD;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: state_r <= S_CALC;
        S_CALC: begin
          diag_r <= drd_r;
          left_r <= cell_cost;
          if (idx_r == ql_r) begin
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + DA_W'(1);
            state_r <= S_READ;
          end
        end
        S_FREAD: state_r <= S_FDATA;
        S_FDATA: begin
          fin_r   <= drd_r;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            dist_r      <= fin_r;
            oovf_r      <= ovf_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/edit_distance_chk.sv =====
// Checker for the edit distance engine: predicts distances and compares results
`timescale 1ns / 1ps
module edit_distance_chk
  import ed_pkg::*;
#(
  parameter int MAX_QUERY = DEF_MAX_QUERY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_ch,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_distance,
  input  logic        out_overflow,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_fold_case,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [15:0] distance;
    logic        overflow;
  } dist_t;

  logic [7:0]  qbytes [MAX_QUERY];
  logic [15:0] row [MAX_QUERY+1];
  int          qlen;
  int          tlen;
  logic        ovf;
  logic        fold;
  dist_t       pending_dist [$];

  function automatic logic [7:0] lower(input logic [7:0] c);
    if (fold && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  task automatic clear_pair();
    qlen = 0;
    tlen = 0;
    ovf  = 1'b0;
    for (int i = 0; i <= MAX_QUERY; i++) row[i] = 16'(i);
  endtask

  task automatic predict_item(input kind_t k, input logic [7:0] c);
    int diag, prev, t;
    logic [7:0] tc;
    dist_t d;
    case (k)
      KIND_CLEAR: clear_pair();
      KIND_QUERY: begin
        if (tlen == 0) begin
          if (qlen >= MAX_QUERY) begin
            ovf = 1'b1;
          end else begin
            qbytes[qlen] = c;
            qlen++;
            row[qlen] = 16'(qlen);
          end
        end
      end
      KIND_TARGET: begin
        if (tlen >= 65535) begin
          ovf = 1'b1;
        end else begin
          tc = lower(c);
          tlen++;
          diag = row[0];
          row[0] = 16'(tlen);
          for (int i = 1; i <= qlen; i++) begin
            prev = row[i];
            t = prev + 1;
            if (row[i-1] + 1 < t) t = row[i-1] + 1;
            if (diag + (lower(qbytes[i-1]) == tc ? 0 : 1) < t)
              t = diag + (lower(qbytes[i-1]) == tc ? 0 : 1);
            if (t > 65535) t = 65535;
            row[i] = 16'(t);
            diag = prev;
          end
        end
      end
      default: begin
        d.distance = row[qlen];
        d.overflow = ovf;
        pending_dist.push_back(d);
      end
    endcase
  endtask

  always @(posedge clk) begin
    dist_t e;
    if (!rst_n) begin
      clear_pair();
      fold = 1'b1;
      pending_dist.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) fold = cfg_fold_case;
      if (out_valid && out_ready) begin
        if (pending_dist.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %0d/%0b", out_distance, out_overflow);
          fail_count <= fail_count + 1;
        end else begin
          e = pending_dist.pop_front();
          if (e.distance !== out_distance || e.overflow !== out_overflow) begin
            if (fail_count < 10)
              $display("mismatch: expected %0d/%0b got %0d/%0b",
                       e.distance, e.overflow, out_distance, out_overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) predict_item(kind_t'(in_kind), in_ch);
    end
    pending_count <= pending_dist.size();
  end

endmodule

// ===== tb/edit_distance_tb.sv =====
// Testbench top for the edit distance engine: stimulus, idling and verdict
`timescale 1ns / 1ps
module edit_distance_tb;
  import ed_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [7:0]  in_ch;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_distance;
  logic        out_overflow;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_fold_case;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_off;

  edit_distance uut (.*);

  edit_distance_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input kind_t k, input logic [7:0] c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= k;
    in_ch    <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_fold(input logic v);
    cfg_valid     <= 1'b1;
    cfg_fold_case <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(input int alpha);
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'($urandom);
    if (r < 4) return 8'h41 + 8'($urandom_range(alpha - 1));
    return 8'h61 + 8'($urandom_range(alpha - 1));
  endfunction

  task automatic random_pair(output int cnt);
    int ql, tl, alpha;
    alpha = $urandom_range(1, 4);
    ql = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
    tl = $urandom_range(0, 10);
    cnt = ql + tl + 2;
    send_item(KIND_CLEAR, 8'($urandom));
    for (int i = 0; i < ql; i++) send_item(KIND_QUERY, pick_byte(alpha));
    for (int i = 0; i < tl; i++) begin
      if ($urandom_range(15) == 0)
        send_item(kind_t'($urandom_range(1, 3)), 8'($urandom));
      else
        send_item(KIND_TARGET, pick_byte(alpha));
    end
    send_item(KIND_FINISH, 8'($urandom));
  endtask

  initial begin
    int n;
    int cnt;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= KIND_CLEAR;
    in_ch         <= 8'h00;
    cfg_valid     <= 1'b0;
    cfg_fold_case <= 1'b1;
    hold_off      <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_FINISH, 8'hFF);
    send_item(KIND_TARGET, 8'h41);
    send_item(KIND_TARGET, 8'h62);
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_CLEAR, 8'hFF);
    send_item(KIND_QUERY, 8'h41);
    send_item(KIND_QUERY, 8'h5A);
    send_item(KIND_QUERY, 8'hFF);
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_TARGET, 8'h61);
    send_item(KIND_QUERY, 8'h00);
    send_item(KIND_TARGET, 8'h7A);
    send_item(KIND_TARGET, 8'hFF);
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_CLEAR, 8'h00);
    for (int i = 0; i < 66; i++) send_item(KIND_QUERY, 8'h40 + 8'(i));
    send_item(KIND_TARGET, 8'h41);
    send_item(KIND_FINISH, 8'h00);
    drain();
    write_fold(1'b0);
    send_item(KIND_CLEAR, 8'h00);
    send_item(KIND_QUERY, 8'h41);
    send_item(KIND_TARGET, 8'h61);
    send_item(KIND_FINISH, 8'h00);
    drain();
    write_fold(1'b1);

    send_idle_pct = 31;
    recv_idle_pct = 71;
    n = 0;
    while (n < 200) begin
      random_pair(cnt);
      n += cnt;
    end
    drain();
    write_fold(1'b0);
    send_idle_pct = 71;
    recv_idle_pct = 31;
    n = 0;
    while (n < 200) begin
      random_pair(cnt);
      n += cnt;
    end
    drain();
    write_fold(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) send_item(KIND_FINISH, 8'($urandom));
      end
    join
    n = 0;
    while (n < 200) begin
      random_pair(cnt);
      n += cnt;
    end
    in_valid <= 1'b0;

    fork
      begin
        while (pending_count != 0) @(posedge clk);
        repeat (300) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
        $display("FAILURE");
        $finish;
      end
    join_any
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
